[rtl/core/kbnp_pkg.sv]
// Shared types and constants for the keyboard new-press queue.
// No dependencies; imported by every module of the block.
`default_nettype none
package kbnp_pkg;

   localparam int KEY_W       = 8;
   localparam int INPUT_SLOTS = 6;
   localparam int MOD_W       = 8;
   localparam int LED_W       = 8;
   localparam int ENTRY_W     = KEY_W + MOD_W + LED_W;
   localparam int REQ_DATA_W  = INPUT_SLOTS * KEY_W + MOD_W + LED_W;

   typedef logic [KEY_W-1:0]   key_type;
   typedef logic [ENTRY_W-1:0] entry_type;

   typedef struct packed {
      logic      valid;
      entry_type data;
   } push_type;

   typedef struct packed {
      logic      hit;
      entry_type data;
   } pop_rsp_type;

endpackage
`default_nettype wire

[rtl/core/kbnp_lane.sv]
// One detection lane: flags its slot as a new press.
// Depends on kbnp_pkg.
`default_nettype none
module kbnp_lane #(
   parameter int KEYS_PER_REPORT = 6,
   parameter int LANE_INDEX      = 0
) (
   input  wire logic [KEYS_PER_REPORT-1:0][kbnp_pkg::KEY_W-1:0] cur_keys,
   input  wire logic [KEYS_PER_REPORT-1:0][kbnp_pkg::KEY_W-1:0] prev_keys,
   output logic                                                 is_new
);
   import kbnp_pkg::*;

   key_type key;
   logic    seen;

   assign key = cur_keys[LANE_INDEX];

   always_comb begin
      seen = 1'b0;
      for (int j = 0; j < KEYS_PER_REPORT; j++) begin
         if (prev_keys[j] == key) seen = 1'b1;
         if (j < LANE_INDEX && cur_keys[j] == key) seen = 1'b1;
      end
      is_new = (key > KEY_W'(1)) && !seen;
   end

endmodule
`default_nettype wire

[rtl/core/kbnp_fifo.sv]
// Press queue: entry memory with write/read pointers and fill count.
// Depends on kbnp_pkg; read data is registered.
`default_nettype none
module kbnp_fifo #(
   parameter int QUEUE_DEPTH = 16
) (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire kbnp_pkg::push_type     push,
   input  wire logic                   pop,
   output kbnp_pkg::pop_rsp_type       pop_rsp
);
   import kbnp_pkg::*;

   localparam int PTR_W = $clog2(QUEUE_DEPTH);
   localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

   entry_type        mem [QUEUE_DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             hit_ff;
   entry_type        rd_data_ff;
   logic             full;
   logic             empty;
   logic             do_push;
   logic             do_pop;

   assign full    = (count_ff == CNT_W'(QUEUE_DEPTH));
   assign empty   = (count_ff == '0);
   assign do_push = push.valid && !full;
   assign do_pop  = pop && !empty;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) count_in = count_ff + 1'b1;
      else if (do_pop && !do_push) count_in = count_ff - 1'b1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
         hit_ff    <= 1'b0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
         hit_ff    <= do_pop;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) mem[wr_ptr_ff] <= push.data;
   end

   always_ff @(posedge clock) begin
      if (do_pop) rd_data_ff <= mem[rd_ptr_ff];
   end

   assign pop_rsp.hit  = hit_ff;
   assign pop_rsp.data = rd_data_ff;

endmodule
`default_nettype wire

[rtl/core/keyboard_report_new_press_queue_top.sv]
// Top level of the keyboard new-press queue: detection lanes, merge/push sequencer,
// press queue and result register. Depends on kbnp_pkg, kbnp_lane and kbnp_fifo.
//
//   channel  dir  tdata (low bit up)                       tuser
//   req_     in   key_0..key_5, modifiers, leds (64 b)     kind
//   rsp_     out  key_code, key_modifiers, key_leds (24 b) key_valid
//
// The lanes judge every slot of a report at once; the queue's single write port then
// takes the new presses in slot order. A pop goes through the registered queue read
// before the beat is loaded. Synchronous reset clears the previous report and empties
// the queue. A waiting result beat holds further items off until taken.
`default_nettype none
module keyboard_report_new_press_queue_top #(
   parameter int QUEUE_DEPTH     = 16,
   parameter int KEYS_PER_REPORT = 6
) (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire logic                                req_tvalid,
   output logic                                     req_tready,
   input  wire logic [kbnp_pkg::REQ_DATA_W-1:0]     req_tdata,  // key_0..key_5, modifiers, leds
   input  wire logic                                req_tuser,  // kind
   output logic                                     rsp_tvalid,
   input  wire logic                                rsp_tready,
   output logic [kbnp_pkg::ENTRY_W-1:0]             rsp_tdata,  // key_code, key_modifiers, key_leds
   output logic                                     rsp_tuser   // key_valid
);
   import kbnp_pkg::*;

   localparam logic [1:0] ST_IDLE = 2'd0;
   localparam logic [1:0] ST_PUSH = 2'd1;
   localparam logic [1:0] ST_POP  = 2'd2;

   localparam int MODS_LSB = INPUT_SLOTS * KEY_W;

   logic [1:0]                              state_ff, state_in;
   logic [KEYS_PER_REPORT-1:0]              pend_ff, pend_in;
   logic [KEYS_PER_REPORT-1:0][KEY_W-1:0]   keys_ff, keys_in;
   logic [KEYS_PER_REPORT-1:0][KEY_W-1:0]   prev_ff, prev_in;
   logic [MOD_W+LED_W-1:0]                  attr_ff, attr_in;
   logic                                    rsp_valid_ff, rsp_valid_in;
   logic                                    rsp_user_ff, rsp_user_in;
   entry_type                               rsp_data_ff, rsp_data_in;

   logic [KEYS_PER_REPORT-1:0][KEY_W-1:0]   cur_keys;
   logic [KEYS_PER_REPORT-1:0]              lane_new;
   logic [KEYS_PER_REPORT-1:0]              pick_oh;
   key_type                                 pick_key;
   logic                                    accept;
   logic                                    pop_req;
   push_type                                push;
   pop_rsp_type                             pop_rsp;

   assign accept  = req_tvalid && req_tready;
   assign pop_req = accept && req_tuser;

   always_comb begin
      for (int i = 0; i < KEYS_PER_REPORT; i++) begin
         if (i < INPUT_SLOTS) cur_keys[i] = req_tdata[i*KEY_W +: KEY_W];
         else cur_keys[i] = '0;
      end
   end

   for (genvar g = 0; g < KEYS_PER_REPORT; g++) begin : g_lane
      kbnp_lane #(
         .KEYS_PER_REPORT (KEYS_PER_REPORT),
         .LANE_INDEX      (g)
      ) u_lane (
         .cur_keys  (cur_keys),
         .prev_keys (prev_ff),
         .is_new    (lane_new[g])
      );
   end

   // merge: take the lowest pending slot each cycle
   always_comb begin
      logic taken;
      taken    = 1'b0;
      pick_oh  = '0;
      pick_key = '0;
      for (int i = 0; i < KEYS_PER_REPORT; i++) begin
         if (pend_ff[i] && !taken) begin
            pick_oh[i] = 1'b1;
            pick_key   = keys_ff[i];
            taken      = 1'b1;
         end
      end
   end

   assign push.valid = (state_ff == ST_PUSH) && (pend_ff != '0);
   assign push.data  = {attr_ff, pick_key};

   kbnp_fifo #(
      .QUEUE_DEPTH (QUEUE_DEPTH)
   ) u_fifo (
      .clock   (clock),
      .reset   (reset),
      .push    (push),
      .pop     (pop_req),
      .pop_rsp (pop_rsp)
   );

   assign req_tready = (state_ff == ST_IDLE) && (!rsp_valid_ff || rsp_tready);

   always_comb begin
      state_in     = state_ff;
      pend_in      = pend_ff;
      keys_in      = keys_ff;
      prev_in      = prev_ff;
      attr_in      = attr_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_user_in  = rsp_user_ff;
      rsp_data_in  = rsp_data_ff;
      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               if (req_tuser) begin
                  state_in = ST_POP;
               end else begin
                  pend_in  = lane_new;
                  keys_in  = cur_keys;
                  prev_in  = cur_keys;
                  attr_in  = req_tdata[MODS_LSB +: MOD_W+LED_W];
                  state_in = (lane_new != '0) ? ST_PUSH : ST_IDLE;
               end
            end
         end
         ST_PUSH: begin
            pend_in = pend_ff & ~pick_oh;
            if ((pend_ff & ~pick_oh) == '0) state_in = ST_IDLE;
         end
         ST_POP: begin
            rsp_valid_in = 1'b1;
            rsp_user_in  = pop_rsp.hit;
            rsp_data_in  = pop_rsp.hit ? pop_rsp.data : '0;
            state_in     = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         pend_ff      <= '0;
         prev_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         pend_ff      <= pend_in;
         prev_ff      <= prev_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      keys_ff     <= keys_in;
      attr_ff     <= attr_in;
      rsp_user_ff <= rsp_user_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser  = rsp_user_ff;
   assign rsp_tdata  = rsp_data_ff;

endmodule
`default_nettype wire

[tb/tb_top.sv]
// Self-checking bench for keyboard_report_new_press_queue_top: drives reports and pop
// requests, predicts queued key presses and compares every result beat.
// Depends on kbnp_pkg and the block's RTL only.
`default_nettype none
module tb_top;
   timeunit 1ns;
   timeprecision 1ps;

   import kbnp_pkg::*;

   localparam int QUEUE_DEPTH = 16;
   localparam int SLOTS       = 6;
   localparam int RANDOM_ITEMS = 1450;

   typedef enum logic {KIND_REPORT = 1'b0, KIND_POP = 1'b1} kind_type;

   typedef struct {
      kind_type                 kind;
      logic [SLOTS-1:0][KEY_W-1:0] keys;
      logic [MOD_W-1:0]         mods;
      logic [LED_W-1:0]         leds;
      bit                       drain;
   } req_item_type;

   typedef struct {
      logic             valid;
      logic [KEY_W-1:0] code;
      logic [MOD_W-1:0] mods;
      logic [LED_W-1:0] leds;
   } key_rsp_type;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   logic [REQ_DATA_W-1:0] req_tdata = '0;   // key_0..key_5, modifiers, leds
   logic                  req_tuser = 1'b0; // kind
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   logic [ENTRY_W-1:0]    rsp_tdata;        // key_code, key_modifiers, key_leds
   logic                  rsp_tuser;        // key_valid

   keyboard_report_new_press_queue_top #(
      .QUEUE_DEPTH     (QUEUE_DEPTH),
      .KEYS_PER_REPORT (SLOTS)
   ) dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   // predictor state
   logic [SLOTS-1:0][KEY_W-1:0] last_report_keys = '0;
   entry_type                   press_store[$];
   key_rsp_type                 expected_keys[$];

   req_item_type req_items[$];
   req_item_type cur_item;
   logic [SLOTS-1:0][KEY_W-1:0] gen_prev = '0;

   int accepted = 0, total_items = 0, results = 0, fails = 0;
   int reports = 0, pops = 0, presses = 0, dropped = 0, empty_pops = 0;
   int hold_cycles = 0, stall_cycles = 0;
   key_rsp_type want;

   initial begin
      forever #10 clock = ~clock;
   end

   initial begin
      repeat (7) @(posedge clock);
      reset <= 1'b0;
   end

   initial begin
      #15ms;
      $display("== FAIL ==");
      $finish;
   end

   function automatic int idle_cycles(bit quiet);
      int r;
      if (quiet) return 0;
      r = $urandom_range(0, 99);
      if (r < 55) return 0;
      if (r < 92) return $urandom_range(1, 3);
      return $urandom_range(8, 40);
   endfunction

   function automatic void apply_item(req_item_type it);
      key_rsp_type r;
      entry_type   e;
      bit          seen;
      if (it.kind == KIND_POP) begin
         pops++;
         r = '{valid: 1'b0, code: '0, mods: '0, leds: '0};
         if (press_store.size() == 0) begin
            empty_pops++;
         end else begin
            e = press_store.pop_front();
            r.valid = 1'b1;
            r.code  = e[7:0];
            r.mods  = e[15:8];
            r.leds  = e[23:16];
         end
         expected_keys.push_back(r);
      end else begin
         reports++;
         for (int i = 0; i < SLOTS; i++) begin
            if (it.keys[i] <= 1) continue;
            seen = 1'b0;
            for (int j = 0; j < SLOTS; j++)
               if (last_report_keys[j] == it.keys[i]) seen = 1'b1;
            for (int j = 0; j < i; j++)
               if (it.keys[j] == it.keys[i]) seen = 1'b1;
            if (!seen) begin
               if (press_store.size() < QUEUE_DEPTH) begin
                  press_store.push_back({it.leds, it.mods, it.keys[i]});
                  presses++;
               end else begin
                  dropped++;
               end
            end
         end
         last_report_keys = it.keys;
      end
   endfunction

   function automatic void add_report(logic [SLOTS-1:0][KEY_W-1:0] keys,
                                      logic [7:0] mods, logic [7:0] leds);
      req_item_type it;
      it = '{kind: KIND_REPORT, keys: keys, mods: mods, leds: leds, drain: 1'b0};
      req_items.push_back(it);
   endfunction

   function automatic void add_pop(bit drain);
      req_item_type it;
      it = '{kind: KIND_POP, keys: (SLOTS*KEY_W)'({$urandom, $urandom}),
             mods: 8'($urandom), leds: 8'($urandom), drain: drain};
      req_items.push_back(it);
   endfunction

   function automatic req_item_type random_report();
      req_item_type it;
      int           r;
      it.kind  = KIND_REPORT;
      it.mods  = 8'($urandom_range(0, 255));
      it.leds  = 8'($urandom_range(0, 255));
      it.drain = 1'b0;
      for (int i = 0; i < SLOTS; i++) begin
         r = $urandom_range(0, 99);
         if (r < 20)      it.keys[i] = 8'($urandom_range(0, 1));
         else if (r < 50) it.keys[i] = gen_prev[$urandom_range(0, SLOTS - 1)];
         else if (r < 85) it.keys[i] = 8'($urandom_range(2, 16));
         else             it.keys[i] = 8'($urandom_range(0, 255));
      end
      gen_prev = it.keys;
      return it;
   endfunction

   // driver
   always @(posedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
      end else begin
         if (req_tvalid && req_tready) begin
            apply_item(cur_item);
            accepted++;
         end
         if (!req_tvalid || req_tready) begin
            if (hold_cycles > 0) begin
               hold_cycles--;
               req_tvalid <= 1'b0;
            end else if (req_items.size() > 0 &&
                         !(req_items[0].drain && expected_keys.size() > 0)) begin
               cur_item = req_items.pop_front();
               req_tvalid <= 1'b1;
               req_tdata  <= {cur_item.leds, cur_item.mods, cur_item.keys};
               req_tuser  <= cur_item.kind;
               hold_cycles = idle_cycles((accepted / 150) % 4 == 3);
            end else begin
               req_tvalid <= 1'b0;
            end
         end
      end
   end

   // monitor
   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            results++;
            if (expected_keys.size() == 0) begin
               $error("unexpected result beat: key_valid %0d tdata %h", rsp_tuser, rsp_tdata);
               fails++;
            end else begin
               want = expected_keys.pop_front();
               if (rsp_tuser !== want.valid) begin
                  $error("key_valid: expected %0d, got %0d", want.valid, rsp_tuser);
                  fails++;
               end
               if (rsp_tdata[7:0] !== want.code) begin
                  $error("key_code: expected %h, got %h", want.code, rsp_tdata[7:0]);
                  fails++;
               end
               if (rsp_tdata[15:8] !== want.mods) begin
                  $error("key_modifiers: expected %h, got %h", want.mods, rsp_tdata[15:8]);
                  fails++;
               end
               if (rsp_tdata[23:16] !== want.leds) begin
                  $error("key_leds: expected %h, got %h", want.leds, rsp_tdata[23:16]);
                  fails++;
               end
            end
            stall_cycles = idle_cycles((results / 60) % 4 == 1);
         end
         if (stall_cycles > 0) begin
            stall_cycles--;
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= 1'b1;
         end
      end
   end

   initial begin
      int           pop_pct;
      req_item_type it;

      // directed: empty pop, duplicates, no-key codes, carry-over, overflow, drain past empty
      add_pop(1'b0);
      add_report({8'd3, 8'd255, 8'd1, 8'd0, 8'd2, 8'd2}, 8'hFF, 8'h00);
      add_report({8'd0, 8'd0, 8'd9, 8'd9, 8'd255, 8'd3}, 8'h00, 8'hFF);
      add_pop(1'b1);
      add_report('0, 8'h55, 8'hAA);
      add_report({8'd15, 8'd14, 8'd13, 8'd12, 8'd11, 8'd10}, 8'h0F, 8'hF0);
      add_report({8'd25, 8'd24, 8'd23, 8'd22, 8'd21, 8'd20}, 8'hA5, 8'h5A);
      add_report({8'd35, 8'd34, 8'd33, 8'd32, 8'd31, 8'd30}, 8'h81, 8'h7E);
      add_report({8'd35, 8'd34, 8'd33, 8'd32, 8'd31, 8'd30}, 8'h00, 8'h00);
      add_pop(1'b1);
      repeat (16) add_pop(1'b0);

      pop_pct = 50;
      for (int n = 0; n < RANDOM_ITEMS; n++) begin
         if (n % 40 == 0) begin
            case ($urandom_range(0, 2))
               0: pop_pct = 15;
               1: pop_pct = 50;
               default: pop_pct = 85;
            endcase
         end
         if ($urandom_range(0, 99) < pop_pct) begin
            add_pop(n % 300 == 150);
         end else begin
            it = random_report();
            it.drain = (n % 300 == 150);
            req_items.push_back(it);
         end
      end
      total_items = req_items.size();

      do @(posedge clock);
      while (accepted < total_items || expected_keys.size() > 0);
      repeat (16) @(posedge clock);

      $display("Covered %0d reports and %0d pops: %0d presses queued, %0d dropped when full,",
               reports, pops, presses, dropped);
      $display("%0d pops on an empty queue, %0d result beats checked.", empty_pops, results);
      if (fails == 0) begin
         $display("== PASS ==");
      end else begin
         $display("== FAIL ==");
      end
      $finish;
   end

endmodule
`default_nettype wire
